[rtl/core/nrpt_pkg.sv]
// Shared constants, types and the arctangent table of the nearest resource tracker.
package nrpt_pkg;

  localparam int BLK_W        = 10;
  localparam int TYPE_W       = 4;
  localparam int RES_W        = 16;
  localparam int COORD_W      = 16;
  localparam int ANGLE_W      = 16;
  localparam int ADDR_W       = BLK_W + TYPE_W;
  localparam int DEPTH        = 1 << ADDR_W;
  localparam int ENTRY_W      = ANGLE_W + RES_W;
  localparam int CORDIC_STEPS = 23;
  localparam int ANG_W        = 23;
  localparam int STEP_W       = 5;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_READ,
    S_WRITE
  } top_state_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_SUM,
    A_SQ,
    A_SQRT,
    A_CORD,
    A_FIN
  } acos_state_t;

  function automatic logic [ANG_W-1:0] cordic_ang(input logic [STEP_W-1:0] idx);
    logic [ANG_W-1:0] a;
    case (idx)
      5'd0:    a = 23'd4194304;
      5'd1:    a = 23'd2476042;
      5'd2:    a = 23'd1308273;
      5'd3:    a = 23'd664100;
      5'd4:    a = 23'd333339;
      5'd5:    a = 23'd166832;
      5'd6:    a = 23'd83436;
      5'd7:    a = 23'd41721;
      5'd8:    a = 23'd20861;
      5'd9:    a = 23'd10430;
      5'd10:   a = 23'd5215;
      5'd11:   a = 23'd2608;
      5'd12:   a = 23'd1304;
      5'd13:   a = 23'd652;
      5'd14:   a = 23'd326;
      5'd15:   a = 23'd163;
      5'd16:   a = 23'd81;
      5'd17:   a = 23'd41;
      5'd18:   a = 23'd20;
      5'd19:   a = 23'd10;
      5'd20:   a = 23'd5;
      5'd21:   a = 23'd3;
      5'd22:   a = 23'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[rtl/core/nearest_resource_per_type_core.sv]
// Top level of the per-block, per-type nearest resource tracker on the unit sphere.
//
//  Channel | Direction | Handshake           | Word
//  in_     | input     | in_valid / in_ready | block index, two Q1.15 vectors, type, id
//  out_    | output    | out_valid/out_ready | block, type, best angle, best id, improved
//
// After a word is accepted, the unit forms the products, sum and square, takes the square
// root (one root bit per cycle), runs the CORDIC (one rotation per cycle), takes the
// angle and does the table read-modify-write; out_valid rises once the output register is
// free. in_ready returns with the result, so no new word is taken before the last is done.
// After reset, all 16384 table entries are cleared (one table entry per cycle) before a word.
// The output register holds a result while the next word is accepted and worked on.
module nearest_resource_per_type_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [nrpt_pkg::BLK_W-1:0]          in_block_index,
  input  logic signed [nrpt_pkg::COORD_W-1:0] in_block_x,
  input  logic signed [nrpt_pkg::COORD_W-1:0] in_block_y,
  input  logic signed [nrpt_pkg::COORD_W-1:0] in_block_z,
  input  logic signed [nrpt_pkg::COORD_W-1:0] in_res_x,
  input  logic signed [nrpt_pkg::COORD_W-1:0] in_res_y,
  input  logic signed [nrpt_pkg::COORD_W-1:0] in_res_z,
  input  logic [nrpt_pkg::TYPE_W-1:0]         in_res_type,
  input  logic [nrpt_pkg::RES_W-1:0]          in_res_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [nrpt_pkg::BLK_W-1:0]          out_block,
  output logic [nrpt_pkg::TYPE_W-1:0]         out_type,
  output logic [nrpt_pkg::ANGLE_W-1:0]        out_best_angle,
  output logic [nrpt_pkg::RES_W-1:0]          out_best_resource,
  output logic                                out_improved
);
  import nrpt_pkg::*;

  top_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]  clr_r;
  logic [BLK_W-1:0]   blk_r;
  logic [TYPE_W-1:0]  typ_r;
  logic [RES_W-1:0]   rid_r;
  logic [ANGLE_W-1:0] angle_r;

  logic               out_valid_r;
  logic [BLK_W-1:0]   out_block_r;
  logic [TYPE_W-1:0]  out_type_r;
  logic [ANGLE_W-1:0] out_angle_r;
  logic [RES_W-1:0]   out_res_r;
  logic               out_imp_r;

  logic               acos_start;
  logic               acos_done;
  logic [ANGLE_W-1:0] acos_angle;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [ANGLE_W-1:0] old_angle;
  logic [RES_W-1:0]   old_res;
  logic               better;
  logic               out_load;

  nrpt_acos u_acos (
    .clk   (clk),
    .rst_n (rst_n),
    .start (acos_start),
    .bx    (in_block_x),
    .by    (in_block_y),
    .bz    (in_block_z),
    .rx    (in_res_x),
    .ry    (in_res_y),
    .rz    (in_res_z),
    .done  (acos_done),
    .angle (acos_angle)
  );

  nrpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_CALC;
      S_CALC:  if (acos_done) state_nxt = S_READ;
      S_READ:  state_nxt = S_WRITE;
      S_WRITE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    old_angle  = ram_rdata[ENTRY_W-1:RES_W];
    old_res    = ram_rdata[RES_W-1:0];
    better     = angle_r < old_angle;
    in_ready   = (state_r == S_IDLE);
    acos_start = in_valid && (state_r == S_IDLE);
    out_load   = (state_r == S_WRITE) && (!out_valid_r || out_ready);
    ram_re     = (state_r == S_READ);
    ram_raddr  = {blk_r, typ_r};
    ram_we     = 1'b0;
    ram_waddr  = {blk_r, typ_r};
    ram_wdata  = {angle_r, rid_r};
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = {{ANGLE_W{1'b1}}, {RES_W{1'b0}}};
      end
      S_WRITE: begin
        ram_we = out_load && better;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acos_start) begin
      blk_r <= in_block_index;
      typ_r <= in_res_type;
      rid_r <= in_res_index;
    end
    if (state_r == S_CALC && acos_done) begin
      angle_r <= acos_angle;
    end
    if (out_load) begin
      out_block_r <= blk_r;
      out_type_r  <= typ_r;
      out_angle_r <= better ? angle_r : old_angle;
      out_res_r   <= better ? rid_r : old_res;
      out_imp_r   <= better;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block         = out_block_r;
  assign out_type          = out_type_r;
  assign out_best_angle    = out_angle_r;
  assign out_best_resource = out_res_r;
  assign out_improved      = out_imp_r;

endmodule

[rtl/core/nrpt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module nrpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/nrpt_acos.sv]
// Great-circle angle unit: dot product, iterative square root and iterative CORDIC arccos.
module nrpt_acos (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [nrpt_pkg::COORD_W-1:0] bx,
  input  logic signed [nrpt_pkg::COORD_W-1:0] by,
  input  logic signed [nrpt_pkg::COORD_W-1:0] bz,
  input  logic signed [nrpt_pkg::COORD_W-1:0] rx,
  input  logic signed [nrpt_pkg::COORD_W-1:0] ry,
  input  logic signed [nrpt_pkg::COORD_W-1:0] rz,
  output logic                                done,
  output logic [nrpt_pkg::ANGLE_W-1:0]        angle
);
  import nrpt_pkg::*;

  localparam logic signed [33:0] ONE_S34 = 34'sd1073741824;
  localparam logic signed [33:0] MONE_S34 = -34'sd1073741824;

  acos_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] bx_r, by_r, bz_r, rx_r, ry_r, rz_r;
  logic signed [31:0] p0_r, p1_r, p2_r;
  logic signed [31:0] d_r;
  logic [60:0] v_r;
  logic [61:0] root_r;
  logic [61:0] bit_r;
  logic signed [32:0] x_r, y_r;
  logic signed [25:0] z_r;
  logic [STEP_W-1:0] i_r;

  logic signed [33:0] sum;
  logic signed [31:0] d_sat;
  logic [30:0] d_mag;
  logic [61:0] dsq;
  logic [61:0] trial;
  logic sq_take;
  logic signed [32:0] xs, ys;
  logic signed [25:0] ang_s;
  logic [24:0] z_clamp;
  logic [16:0] z_round;

  always_comb begin
    sum = 34'(p0_r) + 34'(p1_r) + 34'(p2_r);
    if (sum > ONE_S34) begin
      d_sat = 32'sd1073741824;
    end else if (sum < MONE_S34) begin
      d_sat = -32'sd1073741824;
    end else begin
      d_sat = sum[31:0];
    end
    d_mag = d_r[31] ? 31'(-d_r) : d_r[30:0];
    dsq = 62'(d_mag) * 62'(d_mag);
    trial = root_r + bit_r;
    sq_take = 62'(v_r) >= trial;
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    ang_s = 26'(cordic_ang(i_r));
    if (z_r < 0) begin
      z_clamp = '0;
    end else if (z_r > 26'sd16777216) begin
      z_clamp = 25'd16777216;
    end else begin
      z_clamp = z_r[24:0];
    end
    z_round = 17'((26'(z_clamp) + 26'd128) >> 8);
    angle = z_round[16] ? '1 : z_round[ANGLE_W-1:0];
    done = (state_r == A_FIN);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      A_IDLE: if (start) state_nxt = A_MUL;
      A_MUL:  state_nxt = A_SUM;
      A_SUM:  state_nxt = A_SQ;
      A_SQ:   state_nxt = A_SQRT;
      A_SQRT: if (bit_r[0]) state_nxt = A_CORD;
      A_CORD: if (i_r == STEP_W'(CORDIC_STEPS - 1)) state_nxt = A_FIN;
      A_FIN:  state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      A_IDLE: begin
        if (start) begin
          bx_r <= bx;
          by_r <= by;
          bz_r <= bz;
          rx_r <= rx;
          ry_r <= ry;
          rz_r <= rz;
        end
      end
      A_MUL: begin
        p0_r <= 32'(bx_r) * 32'(rx_r);
        p1_r <= 32'(by_r) * 32'(ry_r);
        p2_r <= 32'(bz_r) * 32'(rz_r);
      end
      A_SUM: begin
        d_r <= d_sat;
      end
      A_SQ: begin
        v_r    <= 61'((62'd1 << 60) - dsq);
        root_r <= '0;
        bit_r  <= 62'd1 << 60;
      end
      A_SQRT: begin
        if (sq_take) begin
          v_r    <= 61'(62'(v_r) - trial);
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          i_r <= '0;
          if (d_r[31]) begin
            x_r <= 33'(sq_take ? (root_r >> 1) + bit_r : root_r >> 1);
            y_r <= -33'(d_r);
            z_r <= 26'sd8388608;
          end else begin
            x_r <= 33'(d_r);
            y_r <= 33'(sq_take ? (root_r >> 1) + bit_r : root_r >> 1);
            z_r <= '0;
          end
        end
      end
      A_CORD: begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + ang_s;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - ang_s;
        end
        i_r <= i_r + STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule
